[rtl/obld_pkg.sv]
// ----------------------------------------------------------------------------
// obld_pkg - shared definitions for the one-button LED dimmer
// Level width, register map codes, configuration and state records, and the
// one-step ramp function.
// ----------------------------------------------------------------------------
package obld_pkg;

   localparam int LevelBits = 8;
   localparam int DutyBits  = 8;
   localparam int CountBits = 16;
   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;

   typedef logic [LevelBits-1:0] level_type;
   typedef logic [CountBits-1:0] count_type;
   typedef logic [7:0]           wait_type;

   localparam level_type LevelMax          = '1;
   localparam count_type PressMax          = '1;
   localparam level_type DefaultLevelReset = LevelBits'(97);

   // Register indexes, taken from the word address of the port.
   typedef enum logic [2:0] {
      CSR_LONG_PRESS   = 3'd0,
      CSR_END_HOLD     = 3'd1,
      CSR_HIGH_LEVEL   = 3'd2,
      CSR_HIGH_TIMEOUT = 3'd3,
      CSR_DEFAULT_LVL  = 3'd4,
      CSR_SLOW_ZONE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      count_type long_press_ticks;
      wait_type  end_hold_ticks;
      level_type high_level;
      count_type high_timeout_ticks;
      level_type default_level;
      level_type slow_zone_level;
   } cfg_type;

   typedef struct packed {
      count_type press_ticks;
      logic      was_down;
      level_type level;
      level_type applied_level;
      level_type saved_level;
      logic      ramp_down;
      wait_type  wait_count;
      logic      at_limit;
      count_type high_countdown;
      logic      skip_next;
   } state_type;

   // Idle dimmer state after reset: everything zero but the saved level.
   localparam state_type StateReset = '{saved_level: DefaultLevelReset, default: '0};

   typedef struct packed {
      logic [DutyBits-1:0] duty_level;
      logic [DutyBits-1:0] compare_value;
      logic                holding_at_limit;
   } result_type;

   // One ramp step in the given direction, wrapping within the level width.
   function automatic level_type step_level(level_type v, logic down);
      return down ? v - level_type'(1) : v + level_type'(1);
   endfunction

endpackage

[rtl/obld_req_if.sv]
// ----------------------------------------------------------------------------
// obld_req_if - button sample channel
// Valid/ready channel that carries one button sample per transfer.
// ----------------------------------------------------------------------------
interface obld_req_if;
   logic valid;
   logic ready;
   logic button_down;

   modport source (output valid, output button_down, input ready);
   modport sink   (input valid, input button_down, output ready);
endinterface

[rtl/obld_rsp_if.sv]
// ----------------------------------------------------------------------------
// obld_rsp_if - dimmer result channel
// Valid/ready channel that carries the applied level and the hold flag.
// ----------------------------------------------------------------------------
interface obld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] duty_level;
   logic [7:0] compare_value;
   logic       holding_at_limit;

   modport source (output valid, output duty_level, output compare_value,
                   output holding_at_limit, input ready);
   modport sink   (input valid, input duty_level, input compare_value,
                   input holding_at_limit, output ready);
endinterface

[rtl/obld_step.sv]
// ----------------------------------------------------------------------------
// obld_step - per-tick next-state logic
// Computes the dimmer state after one button sample and the result it shows.
// ----------------------------------------------------------------------------
module obld_step (
   input  obld_pkg::cfg_type    cfg,
   input  obld_pkg::state_type  cur,
   input  logic                 button_down,
   output obld_pkg::state_type  nxt,
   output obld_pkg::result_type result
);
   import obld_pkg::*;

   always_comb begin
      nxt = cur;

      // Overheat timeout: fall back, arm, or count down (holding at zero).
      if (cur.high_countdown == count_type'(1)) begin
         nxt.level          = cfg.default_level;
         nxt.applied_level  = cfg.default_level;
         nxt.ramp_down      = 1'b0;
         nxt.high_countdown = '0;
      end else if (cur.high_countdown == '0 && cur.level > cfg.high_level) begin
         nxt.high_countdown = cfg.high_timeout_ticks;
      end else if (cur.high_countdown != '0) begin
         nxt.high_countdown = cur.high_countdown - count_type'(1);
      end

      if (button_down) begin
         nxt.high_countdown = '0;
         if (!cur.was_down) begin
            nxt.was_down    = 1'b1;
            nxt.press_ticks = '0;
         end
         if (nxt.press_ticks != PressMax) begin
            nxt.press_ticks = nxt.press_ticks + count_type'(1);
         end
         if (nxt.press_ticks >= cfg.long_press_ticks) begin
            // Long press ramp.
            if (nxt.at_limit) begin
               if (nxt.wait_count == '0) begin
                  nxt.ramp_down = !nxt.ramp_down;
                  nxt.level     = step_level(nxt.level, nxt.ramp_down);
                  nxt.at_limit  = 1'b0;
               end else begin
                  nxt.wait_count = nxt.wait_count - wait_type'(1);
               end
            end else begin
               if (nxt.ramp_down && nxt.level <= level_type'(1)) begin
                  nxt.level      = '0;
                  nxt.at_limit   = 1'b1;
                  nxt.wait_count = cfg.end_hold_ticks;
               end else if (nxt.level < cfg.slow_zone_level) begin
                  if (nxt.skip_next) begin
                     nxt.skip_next = 1'b0;
                  end else begin
                     nxt.level     = step_level(nxt.level, nxt.ramp_down);
                     nxt.skip_next = 1'b1;
                  end
               end else if (!nxt.ramp_down &&
                            nxt.level >= LevelMax - level_type'(1)) begin
                  nxt.level      = LevelMax;
                  nxt.at_limit   = 1'b1;
                  nxt.wait_count = cfg.end_hold_ticks;
               end else begin
                  nxt.level = step_level(nxt.level, nxt.ramp_down);
               end
               nxt.applied_level = nxt.level;
            end
         end
      end else if (cur.was_down) begin
         nxt.was_down = 1'b0;
         if (cur.press_ticks < cfg.long_press_ticks) begin
            // Short press toggles off (saving the level) or back on.
            if (nxt.level != '0) begin
               nxt.saved_level = nxt.level;
               nxt.level       = '0;
            end else begin
               nxt.level = cur.saved_level;
            end
            nxt.applied_level = nxt.level;
         end else begin
            if (nxt.at_limit) begin
               nxt.at_limit   = 1'b0;
               nxt.wait_count = '0;
            end
            nxt.ramp_down = !nxt.ramp_down;
         end
         nxt.press_ticks = '0;
      end

      result.duty_level       = DutyBits'(nxt.applied_level);
      result.compare_value    = DutyBits'(LevelMax - nxt.applied_level);
      result.holding_at_limit = nxt.at_limit;
   end

endmodule

[rtl/one_button_led_dimmer_unit.sv]
// ----------------------------------------------------------------------------
// one_button_led_dimmer_unit - one-button LED dimmer
// Turns one button sample per timer tick into a PWM level: short presses
// toggle the light, long presses ramp it, and a high level times out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                   Handshake
//   req       in         button_down                               valid/ready
//   rsp       out        duty_level, compare_value, holding_at_limit valid/ready
//   csr       in/out     six config registers at byte 4*i          APB, no wait
//
// Every accepted sample yields exactly one result in the next cycle; a new
// sample can be accepted in every cycle unless a stalled result holds the single result register.
// Reset (synchronous, active high) restores the register defaults and the
// idle dimmer state, with the saved level at 97.
// A stalled result stays in the result register; input is still taken in
// the same cycle that the waiting result is transferred.
// ----------------------------------------------------------------------------
module one_button_led_dimmer_unit (
   input  logic                                clock,
   input  logic                                reset,
   obld_req_if.sink                            req,
   obld_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [obld_pkg::CsrAddrBits-1:0]    paddr,
   input  logic [obld_pkg::CsrDataBits-1:0]    pwdata,
   output logic [obld_pkg::CsrDataBits-1:0]    prdata,
   output logic                                pready
);
   import obld_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take_sample;
   logic       csr_write;
   csr_index_type csr_index;

   // ------------------------------------------------------------------
   // Configuration registers. The port never inserts wait states, and a
   // write lands on the access cycle. Word addresses past the register
   // list are ignored on write and read back as zero.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CsrAddrBits-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   cfg_in.long_press_ticks   = pwdata[CountBits-1:0];
            CSR_END_HOLD:     cfg_in.end_hold_ticks     = pwdata[7:0];
            CSR_HIGH_LEVEL:   cfg_in.high_level         = pwdata[LevelBits-1:0];
            CSR_HIGH_TIMEOUT: cfg_in.high_timeout_ticks = pwdata[CountBits-1:0];
            CSR_DEFAULT_LVL:  cfg_in.default_level      = pwdata[LevelBits-1:0];
            CSR_SLOW_ZONE:    cfg_in.slow_zone_level    = pwdata[LevelBits-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LONG_PRESS:   prdata = CsrDataBits'(cfg_ff.long_press_ticks);
         CSR_END_HOLD:     prdata = CsrDataBits'(cfg_ff.end_hold_ticks);
         CSR_HIGH_LEVEL:   prdata = CsrDataBits'(cfg_ff.high_level);
         CSR_HIGH_TIMEOUT: prdata = CsrDataBits'(cfg_ff.high_timeout_ticks);
         CSR_DEFAULT_LVL:  prdata = CsrDataBits'(cfg_ff.default_level);
         CSR_SLOW_ZONE:    prdata = CsrDataBits'(cfg_ff.slow_zone_level);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= count_type'(70);
         cfg_ff.end_hold_ticks     <= 8'd150;
         cfg_ff.high_level         <= level_type'(200);
         cfg_ff.high_timeout_ticks <= count_type'(30000);
         cfg_ff.default_level      <= DefaultLevelReset;
         cfg_ff.slow_zone_level    <= level_type'(30);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------
   // Sample handshake. A sample is taken whenever the result register is
   // empty or its contents are being transferred in this same cycle.
   // ------------------------------------------------------------------
   assign req.ready   = !rsp_valid_ff || rsp.ready;
   assign take_sample = req.valid && req.ready;

   // The whole tick update is one pass of combinational logic.
   obld_step u_step (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .button_down (req.button_down),
      .nxt         (state_in),
      .result      (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take_sample) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Dimmer state moves only when a sample is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_sample) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (take_sample) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.duty_level       = result_ff.duty_level;
   assign rsp.compare_value    = result_ff.compare_value;
   assign rsp.holding_at_limit = result_ff.holding_at_limit;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_result_follows_sample: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> rsp.valid)
      else $error("taken sample did not produce a result");

   a_state_frozen_when_idle: assert property (@(posedge clock) disable iff (reset)
      !take_sample |=> $stable(state_ff))
      else $error("dimmer state changed without a taken sample");

   a_press_tracks_button: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> state_ff.was_down == $past(req.button_down))
      else $error("press flag does not follow the button sample");

   a_press_clears_timeout: assert property (@(posedge clock) disable iff (reset)
      take_sample && req.button_down |=> state_ff.high_countdown == '0)
      else $error("timeout countdown running while the button is held");

endmodule
